// ===== sv/led_fade_frame_buffer_core_defines.svh =====
// Assertion macros for the LED fade frame buffer.
// Uses the clock and reset port names of the including module.
`ifndef LED_FADE_FRAME_BUFFER_CORE_DEFINES_SVH
`define LED_FADE_FRAME_BUFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LFB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfb assertion failed");

// next-cycle implication
`define LFB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfb assertion failed");

`else

`define LFB_ASSERT_NOW(label, ante, cons)
`define LFB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/lfb_pkg.sv =====
// Shared types, constants and channel arithmetic for the LED fade frame buffer.
// No dependencies.
package lfb_pkg;

   // strip geometry
   localparam int PIXEL_COUNT = 64;
   localparam int IDX_W       = 6;
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int STRENGTH_W  = 10;
   localparam int SCALE_W     = 9;

   localparam logic [SCALE_W-1:0] STRENGTH_MAX = 9'd256;
   localparam logic [CHAN_W-1:0]  CHANNEL_MAX  = 8'd255;
   localparam logic [CHAN_W-1:0]  FADE_RESET   = 8'd110;

   // command codes (carried on req_tuser)
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_FADE_FACTOR = 1'b0;

   // output queue
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = 2;
   localparam int OUT_CNT_W  = 3;

   // one result beat
   typedef struct packed {
      logic [IDX_W-1:0]  position;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } lfb_beat_type;

   // output queue status back to the sequencer
   typedef struct packed {
      logic [OUT_CNT_W-1:0] count;
      logic                 empty;
   } lfb_fifo_status_type;

   // (strength * chan) >> 8, strength already clamped to 256
   function automatic logic [CHAN_W-1:0] scale_channel(input logic [SCALE_W-1:0] strength,
                                                       input logic [CHAN_W-1:0] chan);
      logic [SCALE_W+CHAN_W-1:0] prod;
      prod = strength * chan;
      return prod[CHAN_W+7:8];
   endfunction

   // add with saturation at 255
   function automatic logic [CHAN_W-1:0] add_sat(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CHAN_W] ? CHANNEL_MAX : sum[CHAN_W-1:0];
   endfunction

   // (fade * v) >> 7, zero for v <= 1, saturated at 255
   function automatic logic [CHAN_W-1:0] decay_channel(input logic [CHAN_W-1:0] fade,
                                                       input logic [CHAN_W-1:0] v);
      logic [2*CHAN_W-1:0] prod;
      logic [CHAN_W:0]     shifted;
      prod    = fade * v;
      shifted = prod[2*CHAN_W-1:7];
      if (v <= 8'd1) begin
         return '0;
      end
      return shifted[CHAN_W] ? CHANNEL_MAX : shifted[CHAN_W-1:0];
   endfunction

endpackage

// ===== sv/lfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfb_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/lfb_out_fifo.sv =====
// Small output queue for result beats, drives the rsp stream channel.
// Depends on lfb_pkg.
module lfb_out_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lfb_pkg::lfb_beat_type       push_beat,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output lfb_pkg::lfb_beat_type       pop_beat,
   output lfb_pkg::lfb_fifo_status_type status
);
   import lfb_pkg::*;

   lfb_beat_type         slot_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] count_ff, count_in;
   logic                 pop;

   assign pop_valid = (count_ff != '0);
   assign pop_beat  = slot_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

// ===== sv/led_fade_frame_buffer_core.sv =====
// Top level of the LED fade frame buffer: command intake, frame walker, store.
// Depends on lfb_pkg, lfb_ram, lfb_out_fifo and led_fade_frame_buffer_core_defines.svh.
//
//  channel | direction | handshake               | content
//  req     | in        | tvalid/tready           | tuser cmd, tdata index/color/strength
//  rsp     | out       | tvalid/tready           | tdata position/r/g/b, tlast frame end
//  csr     | in/out    | psel/penable/pwrite     | fade_factor at byte address 0
//
// An add command is taken in a single input beat; back-to-back adds run at one per
// cycle through a read-modify-write on the pixel store with one-deep forwarding.
// A frame command holds the input off while the walker reads each pixel once and
// writes back its decayed value; a stalled rsp side slows the walk through the
// four-beat output queue. Reset clears a valid bit per pixel, so the store reads
// as black at once with no clearing pass.
`include "led_fade_frame_buffer_core_defines.svh"

module led_fade_frame_buffer_core (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [5:0] pixel_index, [29:6] color, [39:30] strength
   input  logic [0:0]  req_tuser,   // [0] cmd
   // pixel stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [5:0] pixel_position, [13:6] red_level,
                                    // [21:14] green_level, [29:22] blue_level, zero pad
   output logic        rsp_tlast,   // frame_end
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import lfb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } lfb_state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

   // input fields
   logic                  req_cmd;
   logic [IDX_W-1:0]      req_index;
   logic [PIX_W-1:0]      req_color;
   logic [STRENGTH_W-1:0] req_strength;
   logic [SCALE_W-1:0]    strength_clamped;
   logic                  req_accept;
   logic                  index_ok;

   assign req_cmd      = req_tuser[0];
   assign req_index    = req_tdata[IDX_W-1:0];
   assign req_color    = req_tdata[IDX_W+PIX_W-1:IDX_W];
   assign req_strength = req_tdata[IDX_W+PIX_W+STRENGTH_W-1:IDX_W+PIX_W];

   // registers
   lfb_state_type         state_ff, state_in;
   logic [IDX_W-1:0]      walk_cnt_ff, walk_cnt_in;
   logic [CHAN_W-1:0]     fade_ff, fade_in;
   logic [PIXEL_COUNT-1:0] valid_ff, valid_in;
   logic                  rd_vld_ff;
   logic                  s1_add_ff, s1_add_in;
   logic                  s1_pix_ff, s1_pix_in;
   logic                  s1_last_ff, s1_last_in;
   logic [IDX_W-1:0]      s1_addr_ff, s1_addr_in;
   logic [PIX_W-1:0]      s1_scaled_ff, s1_scaled_in;
   logic                  wb_vld_ff;
   logic [IDX_W-1:0]      wb_addr_ff;
   logic [PIX_W-1:0]      wb_data_ff;

   // store access
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [PIX_W-1:0]      rd_data;
   logic                  wr_en;
   logic [PIX_W-1:0]      wr_data;
   logic [PIX_W-1:0]      cur_pix;

   // output queue
   lfb_beat_type          push_beat;
   lfb_beat_type          pop_beat;
   lfb_fifo_status_type   fifo_status;
   logic [OUT_CNT_W:0]    committed;
   logic                  credit;

   // ---------------- register port ----------------
   logic csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign fade_in    = (csr_write && csr_paddr[CSR_ADDR_W-1] == REG_FADE_FACTOR)
                       ? csr_pwdata[CHAN_W-1:0] : fade_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_FADE_FACTOR)
                       ? {{(32-CHAN_W){1'b0}}, fade_ff} : '0;

   // ---------------- intake and walker ----------------
   assign req_tready       = (state_ff == ST_IDLE);
   assign req_accept       = req_tvalid && req_tready;
   assign index_ok         = ({1'b0, req_index} < (IDX_W+1)'(PIXEL_COUNT));
   assign strength_clamped = (req_strength > STRENGTH_W'(STRENGTH_MAX))
                             ? STRENGTH_MAX : req_strength[SCALE_W-1:0];

   // beats in the queue plus one in flight must leave room
   assign committed = {1'b0, fifo_status.count} + {{OUT_CNT_W{1'b0}}, s1_pix_ff};
   assign credit    = (committed < (OUT_CNT_W+1)'(OUT_DEPTH));

   always_comb begin
      state_in     = state_ff;
      walk_cnt_in  = walk_cnt_ff;
      rd_en        = 1'b0;
      rd_addr      = req_index;
      s1_add_in    = 1'b0;
      s1_pix_in    = 1'b0;
      s1_last_in   = 1'b0;
      s1_addr_in   = req_index;
      s1_scaled_in = {scale_channel(strength_clamped, req_color[23:16]),
                      scale_channel(strength_clamped, req_color[15:8]),
                      scale_channel(strength_clamped, req_color[7:0])};
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_FRAME) begin
                  state_in    = ST_WALK;
                  walk_cnt_in = '0;
               end else begin
                  rd_en     = index_ok;
                  s1_add_in = index_ok;
               end
            end
         end
         ST_WALK: begin
            rd_addr    = walk_cnt_ff;
            s1_addr_in = walk_cnt_ff;
            if (credit) begin
               rd_en       = 1'b1;
               s1_pix_in   = 1'b1;
               s1_last_in  = (walk_cnt_ff == LAST_IDX);
               walk_cnt_in = walk_cnt_ff + 1'b1;
               if (walk_cnt_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- modify and write back ----------------
   // forward the previous cycle's write; unwritten pixels read as black
   always_comb begin
      if (wb_vld_ff && wb_addr_ff == s1_addr_ff) begin
         cur_pix = wb_data_ff;
      end else if (rd_vld_ff) begin
         cur_pix = rd_data;
      end else begin
         cur_pix = '0;
      end
   end

   always_comb begin
      wr_en = s1_add_ff || s1_pix_ff;
      if (s1_pix_ff) begin
         wr_data = {decay_channel(fade_ff, cur_pix[23:16]),
                    decay_channel(fade_ff, cur_pix[15:8]),
                    decay_channel(fade_ff, cur_pix[7:0])};
      end else begin
         wr_data = {add_sat(cur_pix[23:16], s1_scaled_ff[23:16]),
                    add_sat(cur_pix[15:8],  s1_scaled_ff[15:8]),
                    add_sat(cur_pix[7:0],   s1_scaled_ff[7:0])};
      end
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[s1_addr_ff] = 1'b1;
      end
   end

   assign push_beat.position = s1_addr_ff;
   assign push_beat.green    = cur_pix[23:16];
   assign push_beat.red      = cur_pix[15:8];
   assign push_beat.blue     = cur_pix[7:0];
   assign push_beat.last     = s1_last_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         walk_cnt_ff <= '0;
         fade_ff     <= FADE_RESET;
         valid_ff    <= '0;
         s1_add_ff   <= 1'b0;
         s1_pix_ff   <= 1'b0;
         wb_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         walk_cnt_ff <= walk_cnt_in;
         fade_ff     <= fade_in;
         valid_ff    <= valid_in;
         s1_add_ff   <= s1_add_in;
         s1_pix_ff   <= s1_pix_in;
         wb_vld_ff   <= wr_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_addr_ff   <= s1_addr_in;
      s1_scaled_ff <= s1_scaled_in;
      wb_addr_ff   <= s1_addr_ff;
      wb_data_ff   <= wr_data;
      if (rd_en) begin
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // ---------------- pixel store ----------------
   lfb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PIXEL_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- output queue ----------------
   lfb_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_pix_ff),
      .push_beat (push_beat),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_beat  (pop_beat),
      .status    (fifo_status)
   );

   assign rsp_tdata = {2'b00, pop_beat.blue, pop_beat.green, pop_beat.red, pop_beat.position};
   assign rsp_tlast = pop_beat.last;

   // ---------------- checks ----------------
   `LFB_ASSERT_NOW(a_queue_room, s1_pix_ff, fifo_status.count < OUT_CNT_W'(OUT_DEPTH))
   `LFB_ASSERT_NOW(a_one_kind, s1_add_ff, !s1_pix_ff)
   `LFB_ASSERT_NOW(a_last_ends_walk, s1_pix_ff && s1_last_ff, state_ff == ST_IDLE)
   `LFB_ASSERT_NEXT(a_walk_writes, s1_pix_ff, wb_vld_ff && wb_addr_ff == $past(s1_addr_ff))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for led_fade_frame_buffer_core: random add/frame command beats
// against an in-bench model of the pixel store, with fade_factor swept over the APB port.
// Depends on lfb_pkg and the core RTL only.

module tb_top;
   import lfb_pkg::*;

   // one command beat as the sender sees it
   typedef struct packed {
      logic        cmd;
      logic [5:0]  idx;
      logic [23:0] color;
      logic [9:0]  strength;
   } strip_cmd_type;

   // one pixel beat on the result side
   typedef struct packed {
      logic [5:0] position;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } pixel_beat_type;

   localparam int QUIET_LIMIT = 4000;   // cycles with no beat on any port
   localparam int LONG_HOLD   = 300;    // receiver back-pressure stretch
   localparam int DRAIN_WAIT  = 80;     // covers one full frame walk
   localparam logic [CSR_ADDR_W-1:0] FADE_ADDR = {REG_FADE_FACTOR, 2'b00};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [5:0] pixel_index, [29:6] color, [39:30] strength
   logic [0:0]  req_tuser = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [5:0] position, [13:6] red, [21:14] green,
                                  // [29:22] blue, zero pad
   logic        rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   led_fade_frame_buffer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // model state
   logic [7:0] strip_red   [PIXEL_COUNT];
   logic [7:0] strip_green [PIXEL_COUNT];
   logic [7:0] strip_blue  [PIXEL_COUNT];
   logic [7:0] fade_level = FADE_RESET;

   strip_cmd_type  pending_cmds [$];
   pixel_beat_type frame_beats  [$];

   int  cmds_offered = 0;
   int  cmds_taken   = 0;
   int  beat_errors  = 0;
   int  csr_errors   = 0;
   int  quiet_cycles = 0;
   bit  idle_on      = 1'b1;
   int  hold_asked   = 0;

   // ---------------- model arithmetic ----------------

   function automatic logic [7:0] scale_byte(input logic [9:0] strength, input logic [7:0] b);
      logic [8:0]  s;
      logic [16:0] prod;
      s    = (strength > 10'd256) ? 9'd256 : strength[8:0];
      prod = s * b;
      return prod[15:8];
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = a + b;
      return sum[8] ? 8'hff : sum[7:0];
   endfunction

   function automatic logic [7:0] faded(input logic [7:0] fade, input logic [7:0] v);
      logic [15:0] prod;
      logic [8:0]  d;
      prod = fade * v;
      d    = prod[15:7];
      if (v <= 8'd1) return 8'd0;
      return d[8] ? 8'hff : d[7:0];
   endfunction

   // update the store for one accepted command; a frame queues 64 pixel beats
   task automatic apply_strip_cmd(input strip_cmd_type c);
      pixel_beat_type b;
      if (c.cmd == CMD_ADD) begin
         strip_green[c.idx] = sat_add(strip_green[c.idx],
                                      scale_byte(c.strength, c.color[23:16]));
         strip_red[c.idx]   = sat_add(strip_red[c.idx],
                                      scale_byte(c.strength, c.color[15:8]));
         strip_blue[c.idx]  = sat_add(strip_blue[c.idx],
                                      scale_byte(c.strength, c.color[7:0]));
      end else begin
         for (int k = 0; k < PIXEL_COUNT; k++) begin
            b.position = k[5:0];
            b.red      = strip_red[k];
            b.green    = strip_green[k];
            b.blue     = strip_blue[k];
            b.last     = (k == PIXEL_COUNT - 1);
            frame_beats.push_back(b);
            strip_red[k]   = faded(fade_level, strip_red[k]);
            strip_green[k] = faded(fade_level, strip_green[k]);
            strip_blue[k]  = faded(fade_level, strip_blue[k]);
         end
      end
   endtask

   initial begin
      for (int k = 0; k < PIXEL_COUNT; k++) begin
         strip_red[k]   = '0;
         strip_green[k] = '0;
         strip_blue[k]  = '0;
      end
   end

   // ---------------- command driver ----------------
   int gap_left = 0;

   always @(negedge clock) begin
      strip_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && cmds_taken != cmds_offered) begin
         // beat still waiting for tready
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
         gap_left = $urandom_range(0, 15);
         req_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
         c = pending_cmds.pop_front();
         req_tdata  <= {c.strength, c.color, c.idx};
         req_tuser  <= c.cmd;
         req_tvalid <= 1'b1;
         cmds_offered++;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------- pixel receiver ----------------
   int stall_left = 0;
   int hold_left  = 0;
   int hold_done  = 0;

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!reset && hold_asked != hold_done) begin
         hold_done++;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------- monitor, checker, watchdog ----------------
   always @(posedge clock) begin : monitor
      strip_cmd_type  c;
      pixel_beat_type want;
      pixel_beat_type got;
      bit             moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            c.cmd      = req_tuser[0];
            c.idx      = req_tdata[5:0];
            c.color    = req_tdata[29:6];
            c.strength = req_tdata[39:30];
            apply_strip_cmd(c);
            cmds_taken++;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved        = 1'b1;
            got.position = rsp_tdata[5:0];
            got.red      = rsp_tdata[13:6];
            got.green    = rsp_tdata[21:14];
            got.blue     = rsp_tdata[29:22];
            got.last     = rsp_tlast;
            if (frame_beats.size() == 0) begin
               beat_errors++;
               $display("%0t: unexpected pixel beat, expected none, got pos %0d rgb %h %h %h",
                        $time, got.position, got.red, got.green, got.blue);
            end else begin
               want = frame_beats.pop_front();
               if (got != want) begin
                  beat_errors++;
                  $display({"%0t: pixel beat mismatch, expected pos %0d r %0d g %0d b %0d",
                            " last %0d, got pos %0d r %0d g %0d b %0d last %0d"},
                           $time, want.position, want.red, want.green, want.blue, want.last,
                           got.position, got.red, got.green, got.blue, got.last);
               end
            end
         end
      end
      if (csr_psel && csr_penable) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("led_fade_frame_buffer_core regression: fail");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   task automatic queue_add(input logic [5:0] idx, input logic [23:0] color,
                            input logic [9:0] strength);
      strip_cmd_type c;
      c.cmd = CMD_ADD;
      c.idx = idx;
      c.color = color;
      c.strength = strength;
      pending_cmds.push_back(c);
   endtask

   // frame beats carry random don't-care payload
   task automatic queue_frame();
      strip_cmd_type c;
      c.cmd = CMD_FRAME;
      c.idx = 6'($urandom);
      c.color = 24'($urandom);
      c.strength = 10'($urandom);
      pending_cmds.push_back(c);
   endtask

   // wait for the block to go quiet, then past any add still in the pipe
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || cmds_taken != cmds_offered || frame_beats.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // APB write of fade_factor, then read it back
   task automatic set_fade(input logic [7:0] fade);
      logic [31:0] word;
      logic [31:0] seen;
      word = {($urandom_range(0, 1) ? 24'($urandom) : 24'h0), fade};
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= FADE_ADDR;
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      fade_level = fade;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== {24'h0, fade}) begin
         csr_errors++;
         $display("%0t: fade_factor readback mismatch, expected %h, got %h",
                  $time, {24'h0, fade}, seen);
      end
   endtask

   // groups of adds closed by a frame, with a few bare frames
   task automatic queue_random_phase(input int target);
      int         n;
      int         count;
      bit         hot;
      logic [5:0] base;
      logic [9:0] s;
      count = 0;
      while (count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_frame();
            count++;
         end else begin
            n    = $urandom_range(1, 20);
            hot  = ($urandom_range(0, 3) == 0);
            base = 6'($urandom);
            for (int i = 0; i < n; i++) begin
               s = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(200, 300));
               queue_add(hot ? base + 6'($urandom_range(0, 3)) : 6'($urandom),
                         24'($urandom), s);
            end
            queue_frame();
            count += n + 1;
         end
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, clamp, saturation, same-pixel back-to-back adds,
      // channels of one and two before decay; runs at the reset fade
      queue_add(6'd0,  24'hffffff, 10'd1023);
      queue_add(6'd63, 24'hffffff, 10'd256);
      queue_add(6'd63, 24'hffffff, 10'd300);
      queue_add(6'd1,  24'h800000, 10'd0);
      queue_add(6'd2,  24'h00ff00, 10'd255);
      queue_add(6'd3,  24'h0000ff, 10'd257);
      queue_add(6'd4,  24'h010101, 10'd512);
      queue_add(6'd5,  24'habcdef, 10'd128);
      queue_add(6'd6,  24'h404040, 10'd256);
      queue_add(6'd6,  24'h404040, 10'd256);
      queue_add(6'd6,  24'h404040, 10'd256);
      queue_add(6'd7,  24'h020202, 10'd256);
      queue_add(6'd8,  24'h010101, 10'd256);
      queue_add(6'd9,  24'h000000, 10'd1023);
      queue_frame();
      queue_frame();
      queue_add(6'd8,  24'hffffff, 10'd1);
      queue_add(6'd10, 24'h123456, 10'd700);
      queue_frame();
      wait_drained();

      set_fade(8'd128);
      queue_random_phase(75);
      wait_drained();

      // back-pressure stretch with no random idling
      set_fade(8'd0);
      idle_on = 1'b0;
      hold_asked++;
      queue_random_phase(75);
      wait_drained();

      // fade above 128 drives decayed channels into saturation
      idle_on = 1'b1;
      set_fade(8'd255);
      queue_add(6'd20, 24'hffffff, 10'd256);
      queue_add(6'd21, 24'h808080, 10'd256);
      queue_random_phase(70);
      wait_drained();

      set_fade(8'($urandom_range(1, 127)));
      queue_random_phase(75);
      wait_drained();

      // final stretch without idling
      idle_on = 1'b0;
      set_fade(8'($urandom_range(0, 128)));
      queue_random_phase(75);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (beat_errors == 0 && csr_errors == 0 && frame_beats.size() == 0)
         $display("led_fade_frame_buffer_core regression: pass");
      else
         $display("led_fade_frame_buffer_core regression: fail");
      $finish;
   end

endmodule
